// ----- rtl/pper_pkg.sv -----
// ----------------------------------------------------------------------------
// pper_pkg
// Shared constants, types and helpers for the pair potential energy pipeline.
// ----------------------------------------------------------------------------
package pper_pkg;

    localparam int LOG_STEPS  = 32;   // fraction bits of log2(x)
    localparam int DIV_STEPS  = 41;   // quotient bits of D/x below the overflow check
    localparam int TAYLOR_N   = 12;   // terms of the 2^f series
    localparam int SC_LAT     = 2 * TAYLOR_N + 3;
    localparam int LAT        = 1 + 1 + DIV_STEPS + 3 + SC_LAT + 1;

    localparam logic [31:0] LN2_Q32   = 32'd2977044472;
    localparam logic [22:0] LOG2E_Q22 = 23'd6051102;
    localparam logic [56:0] TERM_LIM  = 57'd1 << 56;
    localparam logic [40:0] Q_EXTREME = 41'h101_0000_0000;   // 2^40 + 2^32
    localparam logic [40:0] Q_ONE     = 41'h001_0000_0000;   // 2^32
    localparam logic signed [55:0] G_EXTREME = -(56'sd1 <<< 52);

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_ZERO = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        REG_INV_RM       = 3'd0,
        REG_REPULSE_GAIN = 3'd1,
        REG_DECAY_RATE   = 3'd2,
        REG_POWER_EXP    = 3'd3,
        REG_DISP6_GAIN   = 3'd4,
        REG_DISP8_GAIN   = 3'd5,
        REG_DISP10_GAIN  = 3'd6,
        REG_DAMP_LIMIT   = 3'd7
    } reg_idx_t;

    // log2 / divider pipeline payload
    typedef struct packed {
        logic [31:0] x;
        logic [31:0] m;
        logic [31:0] frac;
        logic [4:0]  p;
        logic [31:0] rem;
        logic [40:0] quo;
        logic        ext;
        logic        ltd;
        logic        zero;
        logic        sat;
    } lgd_t;

    function automatic logic [4:0] lead_one(input logic [31:0] v);
        logic [4:0] pos;
        pos = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (v[i])
            begin
                pos = 5'(i);
            end
        end
        return pos;
    endfunction

endpackage

// ----- rtl/pper_dist_if.sv -----
// ----------------------------------------------------------------------------
// pper_dist_if
// Input channel: one pair distance per item.
// ----------------------------------------------------------------------------
interface pper_dist_if;
    logic        valid;
    logic        ready;
    logic [31:0] distance;

    modport source (output valid, output distance, input ready);
    modport sink   (input valid, input distance, output ready);
endinterface

// ----- rtl/pper_res_if.sv -----
// ----------------------------------------------------------------------------
// pper_res_if
// Result channel: pair energy and status per item.
// ----------------------------------------------------------------------------
interface pper_res_if;
    logic               valid;
    logic               ready;
    logic signed [47:0] energy;
    logic [1:0]         status;

    modport source (output valid, output energy, output status, input ready);
    modport sink   (input valid, input energy, input status, output ready);
endinterface

// ----- rtl/pper_scale2.sv -----
// ----------------------------------------------------------------------------
// pper_scale2
// Pipelined coef * 2^expo: Taylor series for 2^f, then scale, round and clamp.
// ----------------------------------------------------------------------------
module pper_scale2
    import pper_pkg::*;
(
    input  logic               clk,
    input  logic               adv,
    input  logic signed [31:0] coef,
    input  logic signed [55:0] expo,
    output logic signed [57:0] term,
    output logic               sat
);

    logic [31:0]        t_reg;
    logic signed [23:0] n_reg;
    logic [63:0]        t_prod;

    logic [31:0]        pr_reg   [0:TAYLOR_N-1];
    logic [33:0]        suma_reg [0:TAYLOR_N-1];
    logic [31:0]        ta_reg   [0:TAYLOR_N-1];
    logic signed [23:0] na_reg   [0:TAYLOR_N-1];
    logic [32:0]        tm_reg   [0:TAYLOR_N-1];
    logic [33:0]        sumb_reg [0:TAYLOR_N-1];
    logic [31:0]        tb_reg   [0:TAYLOR_N-1];
    logic signed [23:0] nb_reg   [0:TAYLOR_N-1];

    logic [63:0]        mag_reg;
    logic               neg_reg;
    logic signed [23:0] np_reg;
    logic [31:0]        cm;
    logic [63:0]        mag_next;

    logic signed [24:0] sh;
    logic [24:0]        sr;
    logic [119:0]       wide;
    logic [64:0]        rnd;
    logic [56:0]        res_mag;
    logic               res_sat;

    assign t_prod = 64'(expo[31:0]) * 64'(LN2_Q32);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t_reg <= t_prod[63:32];
            n_reg <= expo[55:32];
        end
    end

    for (genvar j = 0; j < TAYLOR_N; j++)
    begin : g_term
        localparam int K = j + 1;
        logic [32:0]        tm_in;
        logic [33:0]        sum_in;
        logic [31:0]        t_in;
        logic signed [23:0] n_in;
        logic [63:0]        prod;
        logic [31:0]        quo;

        if (j == 0)
        begin : g_first
            assign tm_in  = 33'h1_0000_0000;
            assign sum_in = 34'h1_0000_0000;
            assign t_in   = t_reg;
            assign n_in   = n_reg;
        end
        else
        begin : g_next
            assign tm_in  = tm_reg[j-1];
            assign sum_in = sumb_reg[j-1];
            assign t_in   = tb_reg[j-1];
            assign n_in   = nb_reg[j-1];
        end

        assign prod = 64'(tm_in) * 64'(t_in);

        if (K == 1)
        begin : g_div1
            assign quo = pr_reg[j];
        end
        else
        begin : g_divk
            localparam logic [31:0] RECIP = 32'((64'd1 << 32) / K);
            logic [63:0] qp;
            logic [31:0] q0;
            logic [35:0] rem;
            // reciprocal estimate is low by at most one
            assign qp  = 64'(pr_reg[j]) * 64'(RECIP);
            assign q0  = qp[63:32];
            assign rem = 36'(pr_reg[j]) - 36'(q0) * 36'(K);
            assign quo = (rem >= 36'(K)) ? q0 + 32'd1 : q0;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                pr_reg[j]   <= prod[63:32];
                suma_reg[j] <= sum_in;
                ta_reg[j]   <= t_in;
                na_reg[j]   <= n_in;
                tm_reg[j]   <= {1'b0, quo};
                sumb_reg[j] <= suma_reg[j] + 34'(quo);
                tb_reg[j]   <= ta_reg[j];
                nb_reg[j]   <= na_reg[j];
            end
        end
    end

    assign cm       = coef[31] ? 32'(-coef) : 32'(coef);
    assign mag_next = 64'(cm) * 64'(sumb_reg[TAYLOR_N-1][33:2]);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mag_reg <= mag_next;
            neg_reg <= coef[31];
            np_reg  <= nb_reg[TAYLOR_N-1];
        end
    end

    assign sh = 25'(np_reg) - 25'sd22;
    assign sr = 25'(-sh);

    always_comb
    begin
        wide    = 120'(mag_reg) << sh[5:0];
        rnd     = (65'(mag_reg) + (65'd1 << 6'(sr[5:0] - 6'd1))) >> sr[5:0];
        res_mag = '0;
        res_sat = 1'b0;
        priority if (mag_reg == '0)
        begin
            res_mag = '0;
        end
        else if (!sh[24])
        begin
            if (sh > 25'sd56 || wide > 120'(TERM_LIM))
            begin
                res_sat = 1'b1;
                res_mag = TERM_LIM;
            end
            else
            begin
                res_mag = wide[56:0];
            end
        end
        else
        begin
            if (sr > 25'd62)
            begin
                res_mag = '0;
            end
            else if (rnd > 65'(TERM_LIM))
            begin
                res_sat = 1'b1;
                res_mag = TERM_LIM;
            end
            else
            begin
                res_mag = rnd[56:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            term <= neg_reg ? -$signed(58'(res_mag)) : $signed(58'(res_mag));
            sat  <= res_sat;
        end
    end

endmodule

// ----- rtl/pair_potential_energy_eval_top.sv -----
// ----------------------------------------------------------------------------
// pair_potential_energy_eval_top
// Aziz-Chen pair energy for one distance per item, fixed point, fully pipelined.
// ----------------------------------------------------------------------------
// One item per cycle while the result side is not stalling.
// Depth is set by the 41-step restoring divider for D/x (log2 squaring runs
// alongside it) and the 12-term 2^f series in each of the four scale units.
// A stall on the result side freezes the whole pipeline; nothing is dropped.
// Reset clears valid bits and loads the register defaults; no clearing pass.
module pair_potential_energy_eval_top
    import pper_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    pper_dist_if.sink   pdist,
    pper_res_if.source  res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [31:0] inv_rm_reg, repulse_gain_reg, decay_rate_reg, power_exp_reg;
    logic [31:0] disp6_gain_reg, disp8_gain_reg, disp10_gain_reg, damp_limit_reg;

    logic           adv;
    logic [LAT-1:0] vld_reg;

    // ---------------- configuration ----------------
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_rm_reg       <= 32'h0100_0000;
            repulse_gain_reg <= '0;
            decay_rate_reg   <= '0;
            power_exp_reg    <= '0;
            disp6_gain_reg   <= '0;
            disp8_gain_reg   <= '0;
            disp10_gain_reg  <= '0;
            damp_limit_reg   <= 32'h0100_0000;
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (reg_idx_t'(paddr[4:2]))
                REG_INV_RM:       inv_rm_reg       <= pwdata;
                REG_REPULSE_GAIN: repulse_gain_reg <= pwdata;
                REG_DECAY_RATE:   decay_rate_reg   <= pwdata;
                REG_POWER_EXP:    power_exp_reg    <= pwdata;
                REG_DISP6_GAIN:   disp6_gain_reg   <= pwdata;
                REG_DISP8_GAIN:   disp8_gain_reg   <= pwdata;
                REG_DISP10_GAIN:  disp10_gain_reg  <= pwdata;
                REG_DAMP_LIMIT:   damp_limit_reg   <= pwdata;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx_t'(paddr[4:2]))
            REG_INV_RM:       prdata = inv_rm_reg;
            REG_REPULSE_GAIN: prdata = repulse_gain_reg;
            REG_DECAY_RATE:   prdata = decay_rate_reg;
            REG_POWER_EXP:    prdata = power_exp_reg;
            REG_DISP6_GAIN:   prdata = disp6_gain_reg;
            REG_DISP8_GAIN:   prdata = disp8_gain_reg;
            REG_DISP10_GAIN:  prdata = disp10_gain_reg;
            REG_DAMP_LIMIT:   prdata = damp_limit_reg;
        endcase
    end

    // ---------------- pipeline control ----------------
    assign adv         = !vld_reg[LAT-1] || res.ready;
    assign pdist.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[LAT-2:0], pdist.valid};
        end
    end

    // ---------------- reduced distance ----------------
    logic [63:0] rprod;
    logic        x_ovf;
    logic [31:0] x_next;
    logic [31:0] x_reg;
    logic        xsat_reg;

    assign rprod  = 64'(pdist.distance) * 64'(inv_rm_reg);
    assign x_ovf  = |rprod[63:56];
    assign x_next = x_ovf ? '1 : rprod[55:24];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg    <= x_next;
            xsat_reg <= x_ovf;
        end
    end

    // ---------------- log2 and damping divider ----------------
    lgd_t       pipe_reg [0:DIV_STEPS];
    lgd_t       prep;
    logic [4:0] pos;

    always_comb
    begin
        pos       = lead_one(x_reg);
        prep.x    = x_reg;
        prep.m    = x_reg << (5'd31 - pos);
        prep.frac = '0;
        prep.p    = pos;
        prep.rem  = {9'b0, damp_limit_reg[31:9]};
        prep.quo  = '0;
        // quotient of 2^41 or more is extreme damping already
        prep.ext  = {9'b0, damp_limit_reg} >= {x_reg, 9'b0};
        prep.ltd  = x_reg < damp_limit_reg;
        prep.zero = x_reg == '0;
        prep.sat  = xsat_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pipe_reg[0] <= prep;
        end
    end

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_step
        localparam int B = DIV_STEPS - 1 - k;
        logic        nb;
        logic [63:0] sq;
        logic [32:0] tr;
        lgd_t        nxt;

        if (B >= 32)
        begin : g_dbit
            assign nb = damp_limit_reg[B-32];
        end
        else
        begin : g_zbit
            assign nb = 1'b0;
        end

        assign sq = 64'(pipe_reg[k].m) * 64'(pipe_reg[k].m);
        assign tr = {pipe_reg[k].rem, nb};

        always_comb
        begin
            nxt = pipe_reg[k];
            if (k < LOG_STEPS)
            begin
                nxt.m    = sq[63] ? sq[63:32] : sq[62:31];
                nxt.frac = {pipe_reg[k].frac[30:0], sq[63]};
            end
            if (tr >= {1'b0, pipe_reg[k].x})
            begin
                nxt.rem = 32'(tr - {1'b0, pipe_reg[k].x});
                nxt.quo = {pipe_reg[k].quo[39:0], 1'b1};
            end
            else
            begin
                nxt.rem = tr[31:0];
                nxt.quo = {pipe_reg[k].quo[39:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                pipe_reg[k+1] <= nxt;
            end
        end
    end

    // ---------------- exponent build, three stages ----------------
    lgd_t               lz;
    logic signed [37:0] lval;
    logic signed [29:0] lsh;
    logic [40:0]        u;
    logic [27:0]        v;

    logic [55:0]        vsq_reg;
    logic signed [63:0] ax_reg;
    logic signed [61:0] gl_reg;
    logic signed [37:0] l1_reg, l2_reg;
    logic               ltd1_reg, ext1_reg, ltd2_reg, ext2_reg;
    logic [1:0]         side1_reg, side2_reg;

    logic [60:0]        gp_reg;
    logic signed [61:0] ap_reg;
    logic signed [45:0] glr_reg;
    logic signed [37:0] axs;

    assign lz   = pipe_reg[DIV_STEPS];
    assign lval = {6'({1'b0, lz.p}) - 6'd24, lz.frac};
    assign lsh  = 30'(lval >>> 8);
    assign u    = lz.quo - Q_ONE;
    assign v    = u[39:12];
    assign axs  = 38'(ax_reg >>> 26);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vsq_reg   <= 56'(v) * 56'(v);
            ax_reg    <= 64'($signed(decay_rate_reg)) * 64'($signed({1'b0, lz.x}));
            gl_reg    <= 62'(lsh) * 62'($signed(power_exp_reg));
            l1_reg    <= lval;
            ltd1_reg  <= lz.ltd;
            ext1_reg  <= lz.ext || (lz.quo >= Q_EXTREME);
            side1_reg <= {lz.zero, lz.sat};

            gp_reg    <= 61'(vsq_reg[55:18]) * 61'(LOG2E_Q22);
            ap_reg    <= 62'(axs) * 62'($signed({1'b0, LOG2E_Q22}));
            glr_reg   <= 46'(gl_reg >>> 16);
            l2_reg    <= l1_reg;
            ltd2_reg  <= ltd1_reg;
            ext2_reg  <= ext1_reg;
            side2_reg <= side1_reg;
        end
    end

    logic signed [55:0] gv, lx, er;
    logic signed [55:0] exp_reg [0:3];
    logic [1:0]         side_reg [0:SC_LAT];

    always_comb
    begin
        lx = 56'(l2_reg);
        er = 56'(glr_reg) - 56'(ap_reg >>> 12);
        priority if (!ltd2_reg)
        begin
            gv = '0;
        end
        else if (ext2_reg)
        begin
            gv = G_EXTREME;
        end
        else
        begin
            gv = -$signed(56'(gp_reg[60:12]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            exp_reg[0]  <= er;
            exp_reg[1]  <= gv - ((lx <<< 2) + (lx <<< 1));
            exp_reg[2]  <= gv - (lx <<< 3);
            exp_reg[3]  <= gv - ((lx <<< 3) + (lx <<< 1));
            side_reg[0] <= side2_reg;
        end
    end

    // hold zero/overflow flags alongside the scale units
    for (genvar d = 0; d < SC_LAT; d++)
    begin : g_side
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                side_reg[d+1] <= side_reg[d];
            end
        end
    end

    // ---------------- four c*2^E units ----------------
    logic signed [31:0] coef [0:3];
    logic signed [57:0] trm  [0:3];
    logic [3:0]         tsat;

    assign coef[0] = $signed(repulse_gain_reg);
    assign coef[1] = $signed(disp6_gain_reg);
    assign coef[2] = $signed(disp8_gain_reg);
    assign coef[3] = $signed(disp10_gain_reg);

    for (genvar l = 0; l < 4; l++)
    begin : g_lane
        pper_scale2 u_scale2 (
            .clk  (clk),
            .adv  (adv),
            .coef (coef[l]),
            .expo (exp_reg[l]),
            .term (trm[l]),
            .sat  (tsat[l])
        );
    end

    // ---------------- sum and clamp ----------------
    logic signed [59:0] en;
    logic               en_ovf;
    logic signed [47:0] energy_next, energy_reg;
    status_t            status_next, status_reg;

    assign en     = 60'(trm[0]) - 60'(trm[1]) - 60'(trm[2]) - 60'(trm[3]);
    assign en_ovf = !((&en[59:47]) || !(|en[59:47]));

    always_comb
    begin
        energy_next = en_ovf ? (en[59] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}}) : en[47:0];
        priority if (side_reg[SC_LAT][1])
        begin
            energy_next = '0;
            status_next = ST_ZERO;
        end
        else if (side_reg[SC_LAT][0] || (|tsat) || en_ovf)
        begin
            status_next = ST_SAT;
        end
        else
        begin
            status_next = ST_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            energy_reg <= energy_next;
            status_reg <= status_next;
        end
    end

    assign res.valid  = vld_reg[LAT-1];
    assign res.energy = energy_reg;
    assign res.status = status_reg;

    // ---------------- assertions ----------------
    a_zero_energy: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.status == ST_ZERO |-> res.energy == '0)
        else $error("zero-distance result carries nonzero energy");

    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("pipeline valid bits moved during a stall");

    a_x_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[0] && xsat_reg |-> x_reg == '1)
        else $error("overflowed reduced distance not clamped");

endmodule

// ----- tb/sv/tb_pair_potential_energy_eval_top.sv -----
// ----------------------------------------------------------------------------
// tb_pair_potential_energy_eval_top
// Streams pair distances through the energy pipeline under several register
// settings. A local fixed-point model predicts energy and status per item,
// and every result is checked in order against it.
// ----------------------------------------------------------------------------
module tb_pair_potential_energy_eval_top
    import pper_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int    WATCHDOG_LIMIT = 2000;
    localparam int    HOLD_CYCLES    = 300;
    localparam longint TERM_MAX      = 64'sd1 <<< 56;
    localparam longint ENERGY_MAX    = (64'sd1 <<< 47) - 1;
    localparam longint ENERGY_MIN    = -(64'sd1 <<< 47);

    typedef struct {
        logic signed [47:0] energy;
        status_t            status;
    } energy_res_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    pper_dist_if dist_ch();
    pper_res_if  res_ch();

    pair_potential_energy_eval_top DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .pdist   (dist_ch),
        .res     (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    logic [31:0] coef_regs [8];
    logic [31:0] distance_q [$];
    energy_res_t expected_energy_q [$];
    int          err_count;
    int          dist_sent;
    int          res_seen;
    int          src_wait;
    int          rcv_wait;
    int          idle_cycles;

    function automatic longint log2_fix(logic [31:0] x);
        int          p;
        logic [63:0] m;
        logic [31:0] frac;
        p = 31;
        frac = '0;
        while (p > 0 && !x[p])
        begin
            p--;
        end
        m = {32'b0, x} << (31 - p);
        for (int i = 0; i < 32; i++)
        begin
            m = (m * m) >> 31;
            frac = frac << 1;
            if (m >= 64'h1_0000_0000)
            begin
                m = m >> 1;
                frac[0] = 1'b1;
            end
        end
        return longint'(p - 24) * 64'sh1_0000_0000 + longint'({32'b0, frac});
    endfunction

    // c * 2^e with c in Q16.16 and e in Q.32, result Q.24 clamped in magnitude
    function automatic longint scale_pow2(longint c, longint e, inout bit sat);
        longint      n;
        longint      shift;
        logic [63:0] f;
        logic [63:0] t;
        logic [63:0] sum;
        logic [63:0] term;
        logic [63:0] cm;
        logic [63:0] mag;
        n = e >>> 32;
        f = {32'b0, e[31:0]};
        t = (f * 64'(LN2_Q32)) >> 32;
        sum = 64'h1_0000_0000;
        term = 64'h1_0000_0000;
        for (int k = 1; k <= TAYLOR_N; k++)
        begin
            term = ((term * t) >> 32) / 64'(k);
            sum = sum + term;
        end
        cm = (c < 0) ? 64'(-c) : 64'(c);
        mag = cm * (sum >> 2);
        if (mag == 0)
        begin
            return 0;
        end
        shift = n - 22;
        if (shift >= 0)
        begin
            if (shift > 56 || mag > (64'(TERM_MAX) >> shift))
            begin
                sat = 1'b1;
                mag = 64'(TERM_MAX);
            end
            else
            begin
                mag = mag << shift;
            end
        end
        else
        begin
            if (-shift > 62)
            begin
                mag = 0;
            end
            else
            begin
                mag = (mag + (64'd1 << (-shift - 1))) >> (-shift);
            end
            if (mag > 64'(TERM_MAX))
            begin
                sat = 1'b1;
                mag = 64'(TERM_MAX);
            end
        end
        return (c < 0) ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic energy_res_t pair_energy(logic [31:0] r);
        energy_res_t res;
        logic [63:0] xp;
        logic [31:0] x;
        logic [63:0] u;
        logic [63:0] v;
        logic [63:0] u2;
        bit          sat;
        longint      lg;
        longint      er;
        longint      g;
        longint      en;
        sat = 1'b0;
        g = 0;
        xp = ({32'b0, r} * {32'b0, coef_regs[REG_INV_RM]}) >> 24;
        if (xp > 64'hFFFF_FFFF)
        begin
            xp = 64'hFFFF_FFFF;
            sat = 1'b1;
        end
        x = xp[31:0];
        if (x == 0)
        begin
            res.energy = '0;
            res.status = ST_ZERO;
            return res;
        end
        lg = log2_fix(x);
        er = ((longint'(signed'(coef_regs[REG_POWER_EXP])) * (lg >>> 8)) >>> 16)
           - ((((longint'(signed'(coef_regs[REG_DECAY_RATE])) * longint'({32'b0, x}))
                >>> 26) * longint'(LOG2E_Q22)) >>> 12);
        if (x < coef_regs[REG_DAMP_LIMIT])
        begin
            u = ({coef_regs[REG_DAMP_LIMIT], 32'b0} / {32'b0, x}) - 64'h1_0000_0000;
            if (u >= 64'h100_0000_0000)
            begin
                g = -(64'sd1 <<< 52);
            end
            else
            begin
                v = u >> 12;
                u2 = (v * v) >> 8;
                g = -longint'(((u2 >> 10) * 64'(LOG2E_Q22)) >> 12);
            end
        end
        en = scale_pow2(longint'(signed'(coef_regs[REG_REPULSE_GAIN])), er, sat)
           - scale_pow2(longint'(signed'(coef_regs[REG_DISP6_GAIN])), g - 6 * lg, sat)
           - scale_pow2(longint'(signed'(coef_regs[REG_DISP8_GAIN])), g - 8 * lg, sat)
           - scale_pow2(longint'(signed'(coef_regs[REG_DISP10_GAIN])), g - 10 * lg, sat);
        if (en > ENERGY_MAX)
        begin
            en = ENERGY_MAX;
            sat = 1'b1;
        end
        else if (en < ENERGY_MIN)
        begin
            en = ENERGY_MIN;
            sat = 1'b1;
        end
        res.energy = en[47:0];
        res.status = sat ? ST_SAT : ST_OK;
        return res;
    endfunction

    // zero gaps for a stretch of 128 items out of every 512
    function automatic int draw_gap(int count);
        return ((count / 128) % 4 == 3) ? 0 : $urandom_range(0, 19);
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // distance driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            dist_ch.valid <= 1'b0;
            src_wait = 0;
        end
        else
        begin
            if (dist_ch.valid && dist_ch.ready)
            begin
                expected_energy_q.push_back(pair_energy(distance_q.pop_front()));
                dist_sent++;
                src_wait = draw_gap(dist_sent);
            end
            if (!dist_ch.valid || dist_ch.ready)
            begin
                if (src_wait > 0)
                begin
                    src_wait--;
                    dist_ch.valid <= 1'b0;
                end
                else if (distance_q.size() > 0)
                begin
                    dist_ch.valid <= 1'b1;
                    dist_ch.distance <= distance_q[0];
                end
                else
                begin
                    dist_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and checker
    always @(posedge clk)
    begin
        energy_res_t want;
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            rcv_wait = 0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                res_seen++;
                if (expected_energy_q.size() == 0)
                begin
                    $error("result with no item pending: energy %0d status %0d",
                           res_ch.energy, res_ch.status);
                    err_count++;
                end
                else
                begin
                    want = expected_energy_q.pop_front();
                    if (res_ch.energy !== want.energy)
                    begin
                        $error("energy: expected %0d actual %0d", want.energy,
                               res_ch.energy);
                        err_count++;
                    end
                    if (res_ch.status !== want.status)
                    begin
                        $error("status: expected %0d actual %0d", want.status,
                               res_ch.status);
                        err_count++;
                    end
                end
                rcv_wait = (res_seen == 600) ? HOLD_CYCLES : draw_gap(res_seen);
            end
            if (rcv_wait > 0)
            begin
                rcv_wait--;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((dist_ch.valid && dist_ch.ready) || (res_ch.valid && res_ch.ready) || psel)
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic wait_drained();
        while (distance_q.size() > 0 || expected_energy_q.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (LAT + 10) @(posedge clk);
    endtask

    task automatic reg_write(reg_idx_t idx, logic [31:0] val);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        coef_regs[idx] = val;
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic load_coefs(logic [31:0] vals [8]);
        wait_drained();
        for (int i = 0; i < 8; i++)
        begin
            reg_write(reg_idx_t'(i), vals[i]);
        end
    endtask

    function automatic logic [31:0] rand_coef(int idx);
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4: return $urandom;
            default:
            begin
                case (idx)
                    REG_INV_RM:       return $urandom_range(32'h0040_0000, 32'h0200_0000);
                    REG_REPULSE_GAIN: return 32'($signed($urandom_range(0, 32'h0020_0000))
                                                 - 32'sh0010_0000);
                    REG_DECAY_RATE:   return $urandom_range(0, 32'h1000_0000);
                    REG_POWER_EXP:    return 32'($signed($urandom_range(0, 32'h0800_0000))
                                                 - 32'sh0400_0000);
                    REG_DAMP_LIMIT:   return $urandom_range(32'h0080_0000, 32'h0300_0000);
                    default:          return 32'($signed($urandom_range(0, 32'h0008_0000))
                                                 - 32'sh0004_0000);
                endcase
            end
        endcase
    endfunction

    function automatic logic [31:0] rand_distance();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return $urandom_range(0, 255);
            2: return 32'hFFFF_FFFF;
            default: return $urandom_range(32'h0040_0000, 32'h0500_0000);
        endcase
    endfunction

    initial
    begin
        logic [31:0] phase_coefs [8];
        logic [31:0] probe [8];
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        coef_regs = '{32'h0100_0000, 0, 0, 0, 0, 0, 0, 32'h0100_0000};
        probe = '{32'h0000_0000, 32'h0000_0001, 32'h00FF_FFFF, 32'h0100_0000,
                  32'h0180_0000, 32'h0300_0000, 32'h0000_0100, 32'hFFFF_FFFF};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // register defaults
        for (int i = 0; i < 4; i++)
        begin
            distance_q.push_back(probe[i * 2 + 1]);
        end
        // plausible potential, with damping and zero distance
        phase_coefs = '{32'h0100_0000, 32'h0010_0000, 32'h0D00_0000, 32'h0000_0000,
                        32'h0001_0000, 32'h0000_8000, 32'h0000_4000, 32'h013D_70A4};
        load_coefs(phase_coefs);
        foreach (probe[i])
        begin
            distance_q.push_back(probe[i]);
        end
        // extreme gains and scale: reduced distance overflow, term and energy clamp
        phase_coefs = '{32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                        32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};
        load_coefs(phase_coefs);
        foreach (probe[i])
        begin
            distance_q.push_back(probe[i]);
        end
        // zero scale drives every distance to zero
        phase_coefs[REG_INV_RM] = 32'h0000_0000;
        load_coefs(phase_coefs);
        distance_q.push_back(32'h0300_0000);
        distance_q.push_back(32'hFFFF_FFFF);

        for (int ph = 0; ph < 7; ph++)
        begin
            for (int i = 0; i < 8; i++)
            begin
                phase_coefs[i] = rand_coef(i);
            end
            load_coefs(phase_coefs);
            for (int n = 0; n < 275; n++)
            begin
                distance_q.push_back(rand_distance());
                if (distance_q.size() > 16)
                begin
                    @(posedge clk);
                end
            end
        end

        wait_drained();
        if (err_count == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
